// ----- hdl/json_string_unescape_defines.svh -----
// assertion macros for the json string unescaper
// used by json_string_unescape.sv, expects clk_i and rst_ni in scope
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/jsu_pkg.sv -----
// types, character codes and utf-8 encoder for the json string unescaper
// no dependencies
package jsu_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_STR    = 4'd1,
    MODE_ESC    = 4'd2,
    MODE_HEX1   = 4'd3,
    MODE_HIWAIT = 4'd4,
    MODE_HIESC  = 4'd5,
    MODE_HEX2   = 4'd6
  } mode_e;

  typedef enum logic [1:0] {
    END_NONE  = 2'd0,
    END_QUOTE = 2'd1,
    END_ZERO  = 2'd2
  } end_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_CR  = 8'h0D;
  localparam logic [7:0] CTRL_TAB = 8'h09;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    end_e       end_code;
    logic       not_string;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                 n;
    logic [MaxResults-1:0][7:0] bytes;
  } utf8_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.n        = 3'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.n        = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      u.n        = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.n        = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ----- hdl/jsu_stream_if.sv -----
// valid/ready stream channel with a typed payload
// payload types come from jsu_pkg at the point of instantiation
interface jsu_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/json_string_unescape.sv -----
// Unescapes a JSON string literal fed one byte per request, starting at its
// opening quote, and returns the decoded bytes (UTF-8 for \u escapes) plus end
// and not-a-string markers. The input byte is registered, decoded against the
// parse state in one pass, and its results land in a four-entry result register
// that drains one result per cycle while the output is ready. A byte giving at
// most one result is taken every cycle while the output is ready; a \u escape
// yielding n UTF-8 bytes holds the input until its results have drained. A
// result passes the input register and then the result register. Depends on
// jsu_pkg and jsu_stream_if, assertions on json_string_unescape_defines.svh.
`include "json_string_unescape_defines.svh"

module json_string_unescape (
  input  logic         clk_i,
  input  logic         rst_ni,
  jsu_stream_if.sink   in_i,
  jsu_stream_if.source out_o
);

  // input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_move;
  logic       buf_free;

  // parse state
  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [15:0]    acc_q, acc_d;
  logic [9:0]     hsb_q, hsb_d;
  logic           bad_q, bad_d;

  // result register
  logic [2:0]                          res_rem_q, res_rem_d;
  logic [jsu_pkg::MaxResults-1:0][7:0] res_bytes_q, res_bytes_d;
  logic                                res_valid_q, res_valid_d;
  jsu_pkg::end_e                       res_end_q, res_end_d;
  logic                                res_ns_q, res_ns_d;
  logic                                out_take;

  // decode results for the byte in the input stage
  logic [2:0]                          new_n;
  logic [jsu_pkg::MaxResults-1:0][7:0] new_bytes;
  logic                                new_valid;
  jsu_pkg::end_e                       new_end;
  logic                                new_ns;

  logic [7:0]    b;
  logic          is_plain, is_esc;
  logic          hex_ok;
  logic [3:0]    hex_val;
  logic [15:0]   acc_nx;
  logic          bad_nx;
  logic [15:0]   code;
  logic [7:0]    esc_val;
  jsu_pkg::utf8_t u8;

  assign b        = s1_byte_q;
  assign out_take = out_o.valid && out_o.ready;
  assign buf_free = (res_rem_q == 3'd0) || ((res_rem_q == 3'd1) && out_o.ready);
  assign s1_move  = s1_valid_q && buf_free;
  assign in_i.ready = !s1_valid_q || s1_move;

  assign s1_valid_d = (in_i.valid && in_i.ready) ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b >= jsu_pkg::CH_0 && b <= jsu_pkg::CH_9) begin
      hex_val = 4'(b - jsu_pkg::CH_0);
    end else if (b >= jsu_pkg::CH_UA && b <= jsu_pkg::CH_UF) begin
      hex_val = 4'(b - jsu_pkg::CH_UA + 8'd10);
    end else if (b >= jsu_pkg::CH_LA && b <= jsu_pkg::CH_LF) begin
      hex_val = 4'(b - jsu_pkg::CH_LA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    acc_nx = hex_ok ? {acc_q[11:0], hex_val} : acc_q;
    bad_nx = bad_q || !hex_ok;
    code   = bad_nx ? 16'd0 : acc_nx;
  end

  // escape translation
  always_comb begin
    case (b)
      jsu_pkg::CH_B: esc_val = jsu_pkg::CTRL_BS;
      jsu_pkg::CH_F: esc_val = jsu_pkg::CTRL_FF;
      jsu_pkg::CH_N: esc_val = jsu_pkg::CTRL_LF;
      jsu_pkg::CH_R: esc_val = jsu_pkg::CTRL_CR;
      jsu_pkg::CH_T: esc_val = jsu_pkg::CTRL_TAB;
      default:       esc_val = b;
    endcase
  end

  // utf-8 for a single code or a surrogate pair
  always_comb begin
    if (mode_q == jsu_pkg::MODE_HEX2) begin
      u8 = jsu_pkg::utf8_enc(jsu_pkg::SUPP_BASE + {1'b0, hsb_q, code[9:0]});
    end else begin
      u8 = jsu_pkg::utf8_enc({5'd0, code});
    end
  end

  assign is_plain = (mode_q == jsu_pkg::MODE_STR) ||
                    ((mode_q == jsu_pkg::MODE_HIWAIT) && (b != jsu_pkg::CH_BSLASH));
  assign is_esc   = (mode_q == jsu_pkg::MODE_ESC) ||
                    ((mode_q == jsu_pkg::MODE_HIESC) && (b != jsu_pkg::CH_U));

  // next parse state and results
  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    hsb_d     = hsb_q;
    bad_d     = bad_q;
    new_n     = 3'd0;
    new_bytes = '0;
    new_valid = 1'b0;
    new_end   = jsu_pkg::END_NONE;
    new_ns    = 1'b0;
    if (is_plain) begin
      mode_d = jsu_pkg::MODE_STR;
      if (b == jsu_pkg::CH_QUOTE) begin
        new_n   = 3'd1;
        new_end = jsu_pkg::END_QUOTE;
        mode_d  = jsu_pkg::MODE_IDLE;
      end else if (b == jsu_pkg::CH_NUL) begin
        new_n   = 3'd1;
        new_end = jsu_pkg::END_ZERO;
        mode_d  = jsu_pkg::MODE_IDLE;
      end else if (b == jsu_pkg::CH_BSLASH) begin
        mode_d = jsu_pkg::MODE_ESC;
      end else begin
        new_n        = 3'd1;
        new_valid    = 1'b1;
        new_bytes[0] = b;
      end
    end else if (is_esc) begin
      if (b == jsu_pkg::CH_NUL) begin
        new_n   = 3'd1;
        new_end = jsu_pkg::END_ZERO;
        mode_d  = jsu_pkg::MODE_IDLE;
      end else if (b == jsu_pkg::CH_U) begin
        mode_d = jsu_pkg::MODE_HEX1;
        cnt_d  = 2'd0;
        acc_d  = 16'd0;
        bad_d  = 1'b0;
      end else begin
        new_n        = 3'd1;
        new_valid    = 1'b1;
        new_bytes[0] = esc_val;
        mode_d       = jsu_pkg::MODE_STR;
      end
    end else if (mode_q == jsu_pkg::MODE_HIWAIT) begin
      mode_d = jsu_pkg::MODE_HIESC;
    end else if (mode_q == jsu_pkg::MODE_HIESC) begin
      mode_d = jsu_pkg::MODE_HEX2;
      cnt_d  = 2'd0;
      acc_d  = 16'd0;
      bad_d  = 1'b0;
    end else if (mode_q == jsu_pkg::MODE_HEX1 || mode_q == jsu_pkg::MODE_HEX2) begin
      if (b == jsu_pkg::CH_NUL) begin
        new_n   = 3'd1;
        new_end = jsu_pkg::END_ZERO;
        mode_d  = jsu_pkg::MODE_IDLE;
      end else begin
        acc_d = acc_nx;
        bad_d = bad_nx;
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d  = 2'd0;
          mode_d = jsu_pkg::MODE_STR;
          if (mode_q == jsu_pkg::MODE_HEX1) begin
            // zero value and lone low surrogate are dropped
            if (code == 16'd0 ||
                (code >= jsu_pkg::LO_SURR_MIN && code <= jsu_pkg::LO_SURR_MAX)) begin
              new_n = 3'd0;
            end else if (code >= jsu_pkg::HI_SURR_MIN && code <= jsu_pkg::HI_SURR_MAX) begin
              hsb_d  = code[9:0];
              mode_d = jsu_pkg::MODE_HIWAIT;
            end else begin
              new_n     = u8.n;
              new_bytes = u8.bytes;
              new_valid = 1'b1;
            end
          end else if (code >= jsu_pkg::LO_SURR_MIN && code <= jsu_pkg::LO_SURR_MAX) begin
            new_n     = u8.n;
            new_bytes = u8.bytes;
            new_valid = 1'b1;
          end
        end
      end
    end else begin
      // idle, and unused mode codes
      if (b == jsu_pkg::CH_QUOTE) begin
        mode_d = jsu_pkg::MODE_STR;
      end else begin
        mode_d = jsu_pkg::MODE_IDLE;
        new_n  = 3'd1;
        new_ns = 1'b1;
      end
    end
  end

  // result register load and drain
  always_comb begin
    res_rem_d   = res_rem_q;
    res_bytes_d = res_bytes_q;
    res_valid_d = res_valid_q;
    res_end_d   = res_end_q;
    res_ns_d    = res_ns_q;
    if (s1_move) begin
      res_rem_d   = new_n;
      res_bytes_d = new_bytes;
      res_valid_d = new_valid;
      res_end_d   = new_end;
      res_ns_d    = new_ns;
    end else if (out_take) begin
      res_rem_d   = res_rem_q - 3'd1;
      res_bytes_d = {8'h00, res_bytes_q[jsu_pkg::MaxResults-1:1]};
    end
  end

  assign out_o.valid           = (res_rem_q != 3'd0);
  assign out_o.data.out_byte   = res_bytes_q[0];
  assign out_o.data.byte_valid = res_valid_q;
  assign out_o.data.end_code   = res_end_q;
  assign out_o.data.not_string = res_ns_q;
  assign out_o.data.last       = (res_rem_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      res_rem_q  <= 3'd0;
      mode_q     <= jsu_pkg::MODE_IDLE;
      cnt_q      <= 2'd0;
      acc_q      <= 16'd0;
      hsb_q      <= 10'd0;
      bad_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      res_rem_q  <= res_rem_d;
      if (s1_move) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
        acc_q  <= acc_d;
        hsb_q  <= hsb_d;
        bad_q  <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data.in_byte;
    end
    res_bytes_q <= res_bytes_d;
    res_valid_q <= res_valid_d;
    res_end_q   <= res_end_d;
    res_ns_q    <= res_ns_d;
  end

  `JSU_ASSERT_NOW(a_rem_range, 1'b1, res_rem_q <= 3'd4, "result count out of range")
  `JSU_ASSERT_NOW(a_marker_alone, out_o.valid && (res_ns_q || res_end_q != jsu_pkg::END_NONE), !res_valid_q && res_rem_q == 3'd1 && res_bytes_q[0] == 8'h00, "marker result not single")
  `JSU_ASSERT_NEXT(a_stall_holds, out_o.valid && !out_o.ready, res_rem_q == $past(res_rem_q) && res_bytes_q[0] == $past(res_bytes_q[0]), "stalled result changed")
  `JSU_ASSERT_NEXT(a_s1_waits, s1_valid_q && res_rem_q > 3'd1, s1_valid_q && s1_byte_q == $past(s1_byte_q), "input stage lost a byte")

endmodule

// ----- tb/sv/json_string_unescape_checker.sv -----
// checker for the json string unescaper: watches both stream channels,
// predicts the decoded results of every accepted request and compares them
// depends on jsu_pkg for the payload types, modes and character codes
module json_string_unescape_checker
  import jsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  in_item_t    req_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  out_item_t   res_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  mode_e       mode;
  logic [1:0]  ndig;
  logic [15:0] accum;
  logic [9:0]  hi_bits;
  logic        hex_bad;

  out_item_t   burst_q[$];
  out_item_t   decoded_q[$];
  out_item_t   want;
  int unsigned mismatches = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("checker: %s", msg);
    mismatches++;
  endtask

  function automatic void add_result(logic [7:0] b, logic v, end_e e, logic ns);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.end_code   = e;
    r.not_string = ns;
    r.last       = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void add_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(cp[7:0], 1'b1, END_NONE, 1'b0);
    end else if (cp < 21'h800) begin
      add_result(8'hC0 | 8'(cp >> 6), 1'b1, END_NONE, 1'b0);
      add_result(8'h80 | 8'(cp & 21'h3F), 1'b1, END_NONE, 1'b0);
    end else if (cp < 21'h10000) begin
      add_result(8'hE0 | 8'(cp >> 12), 1'b1, END_NONE, 1'b0);
      add_result(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, END_NONE, 1'b0);
      add_result(8'h80 | 8'(cp & 21'h3F), 1'b1, END_NONE, 1'b0);
    end else begin
      add_result(8'hF0 | 8'((cp >> 18) & 21'h07), 1'b1, END_NONE, 1'b0);
      add_result(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b1, END_NONE, 1'b0);
      add_result(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, END_NONE, 1'b0);
      add_result(8'h80 | 8'(cp & 21'h3F), 1'b1, END_NONE, 1'b0);
    end
  endfunction

  function automatic void end_by_zero();
    add_result(8'h00, 1'b0, END_ZERO, 1'b0);
    mode = MODE_IDLE;
  endfunction

  function automatic void begin_hex(mode_e m);
    mode    = m;
    ndig    = '0;
    accum   = '0;
    hex_bad = 1'b0;
  endfunction

  function automatic void take_plain(logic [7:0] b);
    if (b == CH_QUOTE) begin
      add_result(8'h00, 1'b0, END_QUOTE, 1'b0);
      mode = MODE_IDLE;
    end else if (b == CH_NUL) begin
      end_by_zero();
    end else if (b == CH_BSLASH) begin
      mode = MODE_ESC;
    end else begin
      add_result(b, 1'b1, END_NONE, 1'b0);
    end
  endfunction

  function automatic void take_escaped(logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (b == CH_NUL) begin
      end_by_zero();
      return;
    end
    if (b == CH_U) begin
      begin_hex(MODE_HEX1);
      return;
    end
    case (b)
      CH_B: v = CTRL_BS;
      CH_F: v = CTRL_FF;
      CH_N: v = CTRL_LF;
      CH_R: v = CTRL_CR;
      CH_T: v = CTRL_TAB;
      default: ;
    endcase
    add_result(v, 1'b1, END_NONE, 1'b0);
    mode = MODE_STR;
  endfunction

  function automatic void take_hex(logic [7:0] b);
    logic [3:0]  d;
    logic        ok;
    logic [15:0] v;
    if (b == CH_NUL) begin
      end_by_zero();
      return;
    end
    ok = 1'b1;
    d  = '0;
    if (b >= CH_0 && b <= CH_9) d = 4'(b - CH_0);
    else if (b >= CH_UA && b <= CH_UF) d = 4'(b - CH_UA + 8'd10);
    else if (b >= CH_LA && b <= CH_LF) d = 4'(b - CH_LA + 8'd10);
    else ok = 1'b0;
    if (ok) accum = {accum[11:0], d};
    else hex_bad = 1'b1;
    if (ndig < 2'd3) begin
      ndig++;
      return;
    end
    ndig = '0;
    v = hex_bad ? 16'h0000 : accum;
    if (mode == MODE_HEX1) begin
      mode = MODE_STR;
      if (v == 16'h0000 || (v >= LO_SURR_MIN && v <= LO_SURR_MAX)) return;
      if (v >= HI_SURR_MIN && v <= HI_SURR_MAX) begin
        hi_bits = v[9:0];
        mode    = MODE_HIWAIT;
        return;
      end
      add_utf8({5'd0, v});
    end else begin
      mode = MODE_STR;
      if (v >= LO_SURR_MIN && v <= LO_SURR_MAX) add_utf8(SUPP_BASE + {1'b0, hi_bits, v[9:0]});
    end
  endfunction

  function automatic void predict(logic [7:0] b);
    burst_q.delete();
    case (mode)
      MODE_STR: take_plain(b);
      MODE_ESC: take_escaped(b);
      MODE_HEX1, MODE_HEX2: take_hex(b);
      MODE_HIWAIT: begin
        if (b == CH_BSLASH) begin
          mode = MODE_HIESC;
        end else begin
          mode = MODE_STR;
          take_plain(b);
        end
      end
      MODE_HIESC: begin
        if (b == CH_U) begin_hex(MODE_HEX2);
        else take_escaped(b);
      end
      default: begin
        mode = MODE_IDLE;
        if (b == CH_QUOTE) mode = MODE_STR;
        else add_result(8'h00, 1'b0, END_NONE, 1'b1);
      end
    endcase
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i]) decoded_q.push_back(burst_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode    = MODE_IDLE;
      ndig    = '0;
      accum   = '0;
      hi_bits = '0;
      hex_bad = 1'b0;
      decoded_q.delete();
    end else begin
      if (req_valid_i && req_ready_i) predict(req_data_i.in_byte);
      if (res_valid_i && res_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", res_data_i));
        end else begin
          want = decoded_q.pop_front();
          if (res_data_i.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      res_data_i.out_byte, want.out_byte));
          if (res_data_i.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      res_data_i.byte_valid, want.byte_valid));
          if (res_data_i.end_code !== want.end_code)
            report_mismatch($sformatf("end_code %0d, expected %0d",
                                      res_data_i.end_code, want.end_code));
          if (res_data_i.not_string !== want.not_string)
            report_mismatch($sformatf("not_string %b, expected %b",
                                      res_data_i.not_string, want.not_string));
          if (res_data_i.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b",
                                      res_data_i.last, want.last));
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= decoded_q.size();
  end

endmodule

// ----- tb/sv/json_string_unescape_test.sv -----
// testbench top for the json string unescaper: feeds directed and random
// json text with random stalls on both channels and prints the verdict
// depends on jsu_pkg, jsu_stream_if, the block and json_string_unescape_checker
module json_string_unescape_test;
  import jsu_pkg::*;

  localparam int unsigned RandomBytes = 430;
  localparam int unsigned CycleLimit  = 300000;
  localparam logic [15:0] CORNER_CODES [7] = '{
    16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF
  };

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        calm;
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned cycles = 0;
  logic [7:0]  text_q[$];

  jsu_stream_if #(.payload_t(in_item_t))  req_if ();
  jsu_stream_if #(.payload_t(out_item_t)) res_if ();

  json_string_unescape dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  json_string_unescape_checker check_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_data_i  (res_if.data),
    .errors_o    (mismatch_count),
    .pending_o   (results_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(6, 20);
    return $urandom_range(0, 2);
  endfunction

  // stretches without any stalls now and then
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk_i);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int stall;
    stall        = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(n - 4'd10);
  endfunction

  // backslash u and four digits, one of them optionally replaced by junk
  function automatic void push_u(logic [15:0] v, logic spoil);
    int         bad_at;
    logic [7:0] junk;
    bad_at = spoil ? $urandom_range(0, 3) : 4;
    text_q.push_back(CH_BSLASH);
    text_q.push_back(CH_U);
    for (int i = 3; i >= 0; i--) begin
      if (i == bad_at) begin
        if ($urandom_range(0, 3) == 0) begin
          junk = CH_QUOTE;
        end else begin
          do junk = 8'($urandom_range(1, 255));
          while ((junk >= CH_0 && junk <= CH_9) || (junk >= CH_UA && junk <= CH_UF) ||
                 (junk >= CH_LA && junk <= CH_LF));
        end
        text_q.push_back(junk);
      end else begin
        text_q.push_back(hex_char(v[i*4 +: 4]));
      end
    end
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return CORNER_CODES[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic logic [15:0] pick_low();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? LO_SURR_MIN : LO_SURR_MAX;
    return 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
  endfunction

  function automatic void push_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_QUOTE || b == CH_BSLASH);
    text_q.push_back(b);
  endfunction

  function automatic void push_escape();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = CH_B;
      1: b = CH_F;
      2: b = CH_N;
      3: b = CH_R;
      4: b = CH_T;
      5: b = $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH;
      default: begin
        do b = 8'($urandom_range(1, 255));
        while (b == CH_U);
      end
    endcase
    text_q.push_back(CH_BSLASH);
    text_q.push_back(b);
  endfunction

  function automatic void push_unicode();
    logic [15:0] hi;
    int          k;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      push_u(pick_code(), $urandom_range(0, 7) == 0);
    end else if (k == 5) begin
      push_u(pick_low(), 1'b0);
    end else begin
      if ($urandom_range(0, 2) == 0) hi = $urandom_range(0, 1) ? HI_SURR_MIN : HI_SURR_MAX;
      else hi = 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
      push_u(hi, 1'b0);
      case ($urandom_range(0, 7))
        0, 1, 2, 3: push_u(pick_low(), $urandom_range(0, 7) == 0);
        4: push_u(pick_code(), 1'b0);
        5: push_plain();
        6: push_escape();
        default: ;
      endcase
    end
  endfunction

  function automatic void push_string();
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_plain();
        4, 5: push_escape();
        default: push_unicode();
      endcase
    end
    case ($urandom_range(0, 11))
      0: text_q.push_back(CH_NUL);
      1: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_NUL);
      end
      2: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom)));
        text_q.push_back(CH_NUL);
      end
      default: text_q.push_back(CH_QUOTE);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= b;
    do @(posedge clk_i);
    while (!req_if.ready);
  endtask

  task automatic feed_text();
    while (text_q.size() > 0) send_byte(text_q.pop_front());
  endtask

  initial begin
    int unsigned sent;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // not-a-string bytes, a surrogate pair, a quote as hex digit, zero after backslash
    text_q = '{CH_NUL, 8'hFF, CH_QUOTE, 8'hFF, 8'h01};
    push_u(16'hD83D, 1'b0);
    push_u(16'hDE00, 1'b0);
    text_q.push_back(CH_BSLASH);
    text_q.push_back(CH_U);
    text_q.push_back(CH_0);
    text_q.push_back(CH_0);
    text_q.push_back(CH_QUOTE);
    text_q.push_back(CH_0 + 8'd1);
    text_q.push_back(CH_BSLASH);
    text_q.push_back(CH_NUL);
    feed_text();

    sent = 0;
    while (sent < RandomBytes) begin
      if ($urandom_range(0, 99) < 85) push_string();
      else repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom));
      sent += text_q.size();
      feed_text();
    end
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
